>>> rtl/core/mrfr_pkg.sv
`default_nettype none
package mrfr_pkg;

  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,
    CMD_ENTRY   = 2'd1,
    CMD_PAYLOAD = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  localparam logic REG_METER_ADDRESS = 1'b0;
  localparam logic REG_DEVICE_NUMBER = 1'b1;

  localparam logic [7:0] FRAME_START = 8'h68;
  localparam logic [7:0] FRAME_END   = 8'h16;
  localparam logic [7:0] CTRL_READ   = 8'h11;
  localparam logic [7:0] DATA_OFFSET = 8'h33;
  localparam logic [7:0] CTRL_REPLY  = 8'h80;
  localparam logic [7:0] CTRL_ERROR  = 8'hC0;
  localparam logic [7:0] ERR_OTHER   = 8'h01;
  localparam logic [7:0] ERR_DEVICE  = 8'h04;
  localparam logic [7:0] ERR_NO_ID   = 8'h02;

  // frame overhead: two starts, six address, control, length, sum, end
  localparam int unsigned HDR_BYTES   = 12;
  localparam int unsigned REQ_BYTES   = 5;
  localparam logic [5:0]  POS_DATA    = 6'd10;
  localparam logic [5:0]  POS_PAYLOAD = 6'd15;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_CTRL,
    ST_LEN,
    ST_DATA,
    ST_SUM,
    ST_END,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_EMIT
  } st_e;

  typedef struct packed {
    st_e        state;
    logic       in_ready;
    logic       rep_start;
    logic       rep_err;
    logic [7:0] rep_code;
    logic       srch_clr;
    logic       srch_adv;
    logic       emit;
  } ctl_t;

  typedef struct packed {
    logic byte_fire;
    logic frame_start;
    logic len_zero;
    logic data_done;
    logic frame_ok;
    logic err_ctrl;
    logic err_dev;
    logic srch_hit;
    logic srch_last;
    logic gen_last;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/mrfr_in_if.sv
`default_nettype none
interface mrfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  rx_byte;
  logic [3:0]  entry_index;
  logic [31:0] entry_ident;
  logic [5:0]  entry_length;
  logic        entry_valid;
  logic [4:0]  payload_index;
  logic [7:0]  payload_value;

  modport source (output valid, cmd, rx_byte, entry_index, entry_ident, entry_length,
                  entry_valid, payload_index, payload_value, input ready);
  modport sink (input valid, cmd, rx_byte, entry_index, entry_ident, entry_length,
                entry_valid, payload_index, payload_value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mrfr_out_if.sv
`default_nettype none
interface mrfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, tx_byte, last, input ready);
  modport sink (input valid, tx_byte, last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/mrfr_ctrl.sv
`default_nettype none
module mrfr_ctrl
  import mrfr_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_HUNT: begin
        if (sts_i.byte_fire && sts_i.frame_start) state_d = ST_CTRL;
      end
      ST_CTRL: begin
        if (sts_i.byte_fire) state_d = ST_LEN;
      end
      ST_LEN: begin
        if (sts_i.byte_fire) state_d = sts_i.len_zero ? ST_SUM : ST_DATA;
      end
      ST_DATA: begin
        if (sts_i.byte_fire && sts_i.data_done) state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sts_i.byte_fire) state_d = ST_END;
      end
      ST_END: begin
        if (sts_i.byte_fire) begin
          if (!sts_i.frame_ok) state_d = ST_HUNT;
          else if (sts_i.err_ctrl || sts_i.err_dev) state_d = ST_EMIT;
          else state_d = ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: state_d = ST_SRCH_CMP;
      ST_SRCH_CMP: begin
        state_d = (sts_i.srch_hit || sts_i.srch_last) ? ST_EMIT : ST_SRCH_RD;
      end
      ST_EMIT: begin
        if (sts_i.gen_last) state_d = ST_HUNT;
      end
      default: state_d = ST_HUNT;
    endcase
  end

  always_comb begin
    ctl_o           = '0;
    ctl_o.state     = state_q;
    ctl_o.rep_code  = ERR_OTHER;
    case (state_q)
      ST_HUNT, ST_CTRL, ST_LEN, ST_DATA, ST_SUM: ctl_o.in_ready = 1'b1;
      ST_END: begin
        ctl_o.in_ready = 1'b1;
        ctl_o.srch_clr = 1'b1;
        if (sts_i.byte_fire && sts_i.frame_ok && (sts_i.err_ctrl || sts_i.err_dev)) begin
          ctl_o.rep_start = 1'b1;
          ctl_o.rep_err   = 1'b1;
          ctl_o.rep_code  = sts_i.err_ctrl ? ERR_OTHER : ERR_DEVICE;
        end
      end
      ST_SRCH_CMP: begin
        if (sts_i.srch_hit || sts_i.srch_last) begin
          ctl_o.rep_start = 1'b1;
          ctl_o.rep_err   = !sts_i.srch_hit;
          ctl_o.rep_code  = ERR_NO_ID;
        end else begin
          ctl_o.srch_adv = 1'b1;
        end
      end
      ST_EMIT: ctl_o.emit = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/mrfr_dp.sv
`default_nettype none
module mrfr_dp
  import mrfr_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MAX_PAYLOAD   = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [47:0] cfg_wdata_i,
  input  wire         in_valid_i,
  input  wire  [1:0]  cmd_i,
  input  wire  [7:0]  rx_byte_i,
  input  wire  [3:0]  entry_index_i,
  input  wire  [31:0] entry_ident_i,
  input  wire  [5:0]  entry_length_i,
  input  wire         entry_valid_i,
  input  wire  [4:0]  payload_index_i,
  input  wire  [7:0]  payload_value_i,
  input  wire         out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  input  ctl_t        ctl_i,
  output sts_t        sts_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned PDEPTH = TABLE_ENTRIES * MAX_PAYLOAD;
  localparam int unsigned PA_W = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
  localparam logic [5:0] MAX_LEN = 6'(MAX_PAYLOAD);

  logic [47:0] addr_q;
  logic [7:0]  dev_q;

  logic [7:0] win_q [8];
  logic [7:0] win_d [8];
  logic [7:0] full  [8];
  logic [3:0] wcnt_q, wcnt_d;
  logic [7:0] ctrl_q, len_q, sum_q;
  logic       match_q;
  logic [7:0] fpos_q;
  logic [7:0] req_q [REQ_BYTES];

  logic [31:0]      ident_mem [TABLE_ENTRIES];
  logic [5:0]       len_mem   [TABLE_ENTRIES];
  logic [7:0]       pay_mem   [PDEPTH];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IDX_W-1:0] srch_q;
  logic [31:0]      rd_ident_q;
  logic [5:0]       rd_len_q;
  logic [7:0]       pay_rd_q;

  logic [7:0]    rctrl_q, ecode_q, gsum_q, gsum_d;
  logic [5:0]    rlen_q, gpos_q, gpos_d;
  logic          err_q;
  logic [PA_W-1:0] base_q, paddr;

  logic       ovalid_q;
  logic [7:0] obyte_q;
  logic       olast_q;

  logic        fire, byte_fire, hunt_we;
  logic [7:0]  b;
  logic [IDX_W+3:0] eidx;
  logic [IDX_W-1:0] widx;
  logic        idx_ok, pos_ok;
  logic [7:0]  start_sum;
  logic        start_match;
  logic [31:0] req_ident;
  logic [7:0]  dev_dec;
  logic        gen_load, gen_end;
  logic [7:0]  gbyte;
  logic [5:0]  gd, poff;
  logic [2:0]  k;

  assign fire      = in_valid_i && ctl_i.in_ready;
  assign byte_fire = fire && (cmd_i == CMD_BYTE);
  assign hunt_we   = byte_fire && (ctl_i.state == ST_HUNT);
  assign b         = rx_byte_i;
  assign eidx      = {{IDX_W{1'b0}}, entry_index_i};
  assign widx      = eidx[IDX_W-1:0];
  assign idx_ok    = eidx < (IDX_W+4)'(TABLE_ENTRIES);
  assign pos_ok    = 6'(payload_index_i) < MAX_LEN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      dev_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_METER_ADDRESS) addr_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_DEVICE_NUMBER) dev_q <= cfg_wdata_i[7:0];
    end
  end

  always_comb begin
    start_sum   = 8'(FRAME_START + FRAME_START);
    start_match = 1'b1;
    for (int i = 0; i < 6; i++) begin
      start_sum = start_sum + win_q[i+1];
      if (win_q[i+1] != addr_q[8*i +: 8]) start_match = 1'b0;
    end
  end

  // hunt window: append, then realign on the next start byte when eight do not frame
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      win_d[j] = win_q[j];
      full[j]  = win_q[j];
    end
    full[7] = b;
    wcnt_d  = wcnt_q;
    k       = 3'd0;
    if (hunt_we) begin
      if (wcnt_q == 4'd0) begin
        if (b == FRAME_START) begin
          win_d[0] = b;
          wcnt_d   = 4'd1;
        end
      end else if (wcnt_q < 4'd7) begin
        win_d[wcnt_q[2:0]] = b;
        wcnt_d = wcnt_q + 4'd1;
      end else if (b == FRAME_START) begin
        win_d[7] = b;
        wcnt_d   = 4'd8;
      end else begin
        for (int i = 6; i >= 1; i--) begin
          if (full[i] == FRAME_START) k = 3'(i);
        end
        if (k == 3'd0) begin
          wcnt_d = 4'd0;
        end else begin
          for (int j = 0; j < 8; j++) begin
            if (j + int'(k) < 8) win_d[j] = full[3'(j + int'(k))];
          end
          wcnt_d = 4'd8 - {1'b0, k};
        end
      end
    end
    if (byte_fire && ctl_i.state == ST_END) wcnt_d = 4'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q  <= '0;
      ctrl_q  <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      match_q <= 1'b0;
      fpos_q  <= '0;
      for (int j = 0; j < 8; j++) win_q[j] <= '0;
    end else begin
      wcnt_q <= wcnt_d;
      for (int j = 0; j < 8; j++) win_q[j] <= win_d[j];
      if (byte_fire) begin
        case (ctl_i.state)
          ST_HUNT: begin
            if (sts_o.frame_start) begin
              sum_q   <= start_sum;
              match_q <= start_match;
              fpos_q  <= '0;
            end
          end
          ST_CTRL: begin
            ctrl_q <= b;
            sum_q  <= sum_q + b;
          end
          ST_LEN: begin
            len_q  <= b;
            sum_q  <= sum_q + b;
            fpos_q <= '0;
          end
          ST_DATA: begin
            sum_q  <= sum_q + b;
            fpos_q <= fpos_q + 8'd1;
          end
          ST_SUM: sum_q <= sum_q - b;
          ST_END: fpos_q <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_fire && ctl_i.state == ST_DATA && fpos_q < 8'(REQ_BYTES)) begin
      req_q[fpos_q[2:0]] <= b;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) req_ident[8*i +: 8] = req_q[i] - DATA_OFFSET;
    dev_dec = req_q[4] - DATA_OFFSET;
  end

  // entry table and payload store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (fire && cmd_i == CMD_ENTRY && idx_ok) begin
      valid_q[widx] <= entry_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && cmd_i == CMD_ENTRY && idx_ok) begin
      ident_mem[widx] <= entry_ident_i;
      len_mem[widx]   <= (entry_length_i > MAX_LEN) ? MAX_LEN : entry_length_i;
    end
    rd_ident_q <= ident_mem[srch_q];
    rd_len_q   <= len_mem[srch_q];
  end

  always_ff @(posedge clk_i) begin
    if (fire && cmd_i == CMD_PAYLOAD && idx_ok && pos_ok) begin
      pay_mem[PA_W'(widx) * PA_W'(MAX_PAYLOAD) + PA_W'(payload_index_i)] <= payload_value_i;
    end
    pay_rd_q <= pay_mem[paddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_q <= '0;
    end else if (ctl_i.srch_clr) begin
      srch_q <= '0;
    end else if (ctl_i.srch_adv) begin
      srch_q <= srch_q + IDX_W'(1);
    end
  end

  // reply generator
  assign gen_load = ctl_i.emit && (!ovalid_q || out_ready_i);
  assign gen_end  = {1'b0, gpos_q} == ({1'b0, rlen_q} + 7'(HDR_BYTES - 1));
  assign gd       = gpos_q - POS_DATA;

  always_comb begin
    if (gpos_q == 6'd0 || gpos_q == 6'd7) gbyte = FRAME_START;
    else if (gpos_q < 6'd7) gbyte = win_q[gpos_q[2:0]];
    else if (gpos_q == 6'd8) gbyte = rctrl_q;
    else if (gpos_q == 6'd9) gbyte = {2'b00, rlen_q};
    else if (gd < rlen_q) begin
      if (err_q) gbyte = ecode_q + DATA_OFFSET;
      else if (gd < 6'(REQ_BYTES)) gbyte = req_q[gd[2:0]];
      else gbyte = pay_rd_q + DATA_OFFSET;
    end else if (gd == rlen_q) gbyte = gsum_q;
    else gbyte = FRAME_END;
  end

  always_comb begin
    gpos_d = gpos_q;
    gsum_d = gsum_q;
    if (ctl_i.rep_start) begin
      gpos_d = '0;
      gsum_d = '0;
    end else if (gen_load) begin
      gpos_d = gpos_q + 6'd1;
      gsum_d = gsum_q + gbyte;
    end
    // read address follows the next position so the byte is ready when shown
    poff  = gpos_d - POS_PAYLOAD;
    paddr = base_q;
    if (!err_q && gpos_d >= POS_PAYLOAD && (gpos_d - POS_DATA) < rlen_q) begin
      paddr = base_q + PA_W'(poff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpos_q <= '0;
      gsum_q <= '0;
      err_q  <= 1'b0;
    end else begin
      gpos_q <= gpos_d;
      gsum_q <= gsum_d;
      if (ctl_i.rep_start) err_q <= ctl_i.rep_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rep_start) begin
      ecode_q <= ctl_i.rep_code;
      rctrl_q <= ctrl_q | (ctl_i.rep_err ? CTRL_ERROR : CTRL_REPLY);
      rlen_q  <= ctl_i.rep_err ? 6'd1 : 6'(REQ_BYTES) + rd_len_q;
      base_q  <= PA_W'(srch_q) * PA_W'(MAX_PAYLOAD);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (gen_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen_load) begin
      obyte_q <= gbyte;
      olast_q <= gen_end;
    end
  end

  assign out_valid_o = ovalid_q;
  assign tx_byte_o   = obyte_q;
  assign last_o      = olast_q;

  always_comb begin
    sts_o             = '0;
    sts_o.byte_fire   = byte_fire;
    sts_o.frame_start = (wcnt_q == 4'd7) && (b == FRAME_START);
    sts_o.len_zero    = (b == 8'd0);
    sts_o.data_done   = ({1'b0, fpos_q} + 9'd1) >= {1'b0, len_q};
    sts_o.frame_ok    = (b == FRAME_END) && (sum_q == 8'd0) && match_q;
    sts_o.err_ctrl    = (ctrl_q != CTRL_READ) || (len_q < 8'(REQ_BYTES));
    sts_o.err_dev     = (dev_dec != dev_q);
    sts_o.srch_hit    = valid_q[srch_q] && (rd_ident_q == req_ident);
    sts_o.srch_last   = ({1'b0, srch_q} == (IDX_W+1)'(TABLE_ENTRIES - 1));
    sts_o.gen_last    = gen_load && gen_end;
  end

endmodule
`default_nettype wire

>>> rtl/core/meter_read_frame_responder.sv
// Meter read responder: answers read requests found in a received line byte stream.
// req_i carries one item per handshake: cmd 0 is a line byte, cmd 1 writes a table
// entry header (identifier, length, valid), cmd 2 writes one payload byte.
// rsp_o carries the reply frame, one byte per item, last set on the closing byte.
// Input items are taken one per cycle while a frame is being received or hunted.
// A good frame ends with its end byte; then input stalls until the reply is fully
// generated. A bad control, length or device number gives a 13-byte error reply.
// Read replies search the table, a read state and a compare state per entry, and
// a miss also gives that error reply; a hit emits 17 plus entry length bytes at one
// per cycle while the receiver takes them, through a one-item output register, so
// a stalled receiver holds the generator but never loses or repeats a byte; input
// resumes once the final byte is loaded even if it still waits to be taken.
// Configuration writes take effect at once; write only while idle.
// Reset clears the table valid bits, the hunt window and the config registers;
// payload bytes read back only once written.
`default_nettype none
module meter_read_frame_responder
  import mrfr_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned MAX_PAYLOAD   = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_idx_i,
  input  wire  [47:0] cfg_wdata_i,
  mrfr_in_if.sink     req_i,
  mrfr_out_if.source  rsp_o
);

  ctl_t ctl;
  sts_t sts;

  assign req_i.ready = ctl.in_ready;

  mrfr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctl_o  (ctl)
  );

  mrfr_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_PAYLOAD   (MAX_PAYLOAD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (req_i.valid),
    .cmd_i           (req_i.cmd),
    .rx_byte_i       (req_i.rx_byte),
    .entry_index_i   (req_i.entry_index),
    .entry_ident_i   (req_i.entry_ident),
    .entry_length_i  (req_i.entry_length),
    .entry_valid_i   (req_i.entry_valid),
    .payload_index_i (req_i.payload_index),
    .payload_value_i (req_i.payload_value),
    .out_ready_i     (rsp_o.ready),
    .out_valid_o     (rsp_o.valid),
    .tx_byte_o       (rsp_o.tx_byte),
    .last_o          (rsp_o.last),
    .ctl_i           (ctl),
    .sts_o           (sts)
  );

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.last |-> rsp_o.tx_byte == FRAME_END)
    else $error("reply closing byte is not the end code");

  a_no_input_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.state == ST_SRCH_RD || ctl.state == ST_SRCH_CMP || ctl.state == ST_EMIT)
      |-> !req_i.ready)
    else $error("input accepted during search or reply");

  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rep_start |=> ctl.state == ST_EMIT)
    else $error("reply setup not followed by emission");

endmodule
`default_nettype wire
